// File: design/itc_pkg.sv
package itc_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // ASCII codes of the characters that take part in the conversion
    localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
    localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
    localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
    localparam logic [7:0] CH_ADD   = 8'h2B;  // '+'
    localparam logic [7:0] CH_SUB   = 8'h2D;  // '-'
    localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'

    // Command codes of an input item
    localparam logic CMD_CHAR  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Stack entry codes
    typedef enum logic [2:0] {
        CODE_OPEN = 3'd0,
        CODE_ADD  = 3'd1,
        CODE_SUB  = 3'd2,
        CODE_MUL  = 3'd3,
        CODE_DIV  = 3'd4
    } t_code;

    // Move applied to the whole row of stack cells together
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_PUSH,
        SH_POP
    } t_shift;

    // Character classes
    typedef enum logic [2:0] {
        K_ALNUM,
        K_OPEN,
        K_CLOSE,
        K_OPER,
        K_OTHER
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } t_state;

    function automatic t_kind char_kind(input logic [7:0] ch);
        t_kind k;
        if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
            (ch >= 8'h30 && ch <= 8'h39)) begin
            k = K_ALNUM;
        end else if (ch == CH_OPEN) begin
            k = K_OPEN;
        end else if (ch == CH_CLOSE) begin
            k = K_CLOSE;
        end else if (ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV) begin
            k = K_OPER;
        end else begin
            k = K_OTHER;
        end
        return k;
    endfunction

    function automatic t_code char_code(input logic [7:0] ch);
        t_code c;
        case (ch)
            CH_ADD:  c = CODE_ADD;
            CH_SUB:  c = CODE_SUB;
            CH_MUL:  c = CODE_MUL;
            CH_DIV:  c = CODE_DIV;
            default: c = CODE_OPEN;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] code_char(input t_code c);
        logic [7:0] ch;
        unique case (c)
            CODE_OPEN: ch = CH_OPEN;
            CODE_ADD:  ch = CH_ADD;
            CODE_SUB:  ch = CH_SUB;
            CODE_MUL:  ch = CH_MUL;
            CODE_DIV:  ch = CH_DIV;
            default:   ch = 8'h00;
        endcase
        return ch;
    endfunction

    // High precedence: '*' and '/'
    function automatic logic prec_hi(input t_code c);
        return (c == CODE_MUL) || (c == CODE_DIV);
    endfunction

endpackage

// File: design/itc_in_if.sv
interface itc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] char_in;

    modport source (output valid, output command, output char_in, input ready);
    modport sink   (input valid, input command, input char_in, output ready);
endinterface

// File: design/itc_out_if.sv
interface itc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       run_last;
    logic       overflow;

    modport source (output valid, output char_out, output run_last, output overflow,
                    input ready);
    modport sink   (input valid, input char_out, input run_last, input overflow,
                    output ready);
endinterface

// File: design/infix_to_postfix_converter_unit.sv
// Shunting-yard infix-to-postfix converter. Characters come in one item at a time
// (command 0) and postfix characters go out; command 1 flushes the operator stack,
// emitting any unmatched '(' as is, then clears the sticky overflow flag. The operator
// stack is a row of STACK_DEPTH cells that shift together, top in cell 0, so one
// entry is pushed or popped per cycle unless a stalled output holds a pop. An item
// is accepted only while idle and then worked: a letter or digit goes straight out,
// a '(' that a ')' discards gives no result, and any other entry popped from the
// stack goes out as its character. Each result occupies the output register until
// taken; a stalled output holds the work while it stalls, but the next item may be
// accepted once the current one is done. run_last marks the last result of an item.
module infix_to_postfix_converter_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    itc_in_if.sink         i_in,
    itc_out_if.source      o_out
);

    localparam int DEPTH = itc_pkg::STACK_DEPTH;
    localparam int CW    = itc_pkg::CNT_W;

    itc_pkg::t_state r_state, n_state;
    logic            r_cmd;
    logic [7:0]      r_char;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;

    logic            r_out_valid;
    logic [7:0]      r_out_char;
    logic            r_out_last;
    logic            r_out_ovf;

    itc_pkg::t_shift shift;
    itc_pkg::t_code  push_code;
    itc_pkg::t_code  cell_q [DEPTH];
    logic            emit;
    logic [7:0]      emit_char;
    logic            emit_last;
    logic            can_emit;
    itc_pkg::t_kind  kind;
    itc_pkg::t_code  top, next;
    logic            cnt_one, cnt_zero, full;

    // Row of stack cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        itc_pkg::t_code from_up, from_down;
        if (g == 0) begin : g_top
            assign from_up = push_code;
        end else begin : g_mid
            assign from_up = cell_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_bot
            assign from_down = cell_q[g];
        end else begin : g_nbot
            assign from_down = cell_q[g+1];
        end
        itc_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (shift),
            .i_from_up   (from_up),
            .i_from_down (from_down),
            .o_code      (cell_q[g])
        );
    end

    assign top      = cell_q[0];
    assign next     = cell_q[1];
    assign cnt_zero = (r_count == '0);
    assign cnt_one  = (r_count == CW'(1));
    assign full     = (r_count == CW'(DEPTH));
    assign kind     = itc_pkg::char_kind(r_char);
    assign can_emit = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == itc_pkg::ST_IDLE);

    // Sequencer: one stack move or one result per cycle; a result waits for a free output
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        shift     = itc_pkg::SH_HOLD;
        push_code = itc_pkg::char_code(r_char);
        emit      = 1'b0;
        emit_char = itc_pkg::code_char(top);
        emit_last = 1'b0;
        unique case (r_state)
            itc_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = itc_pkg::ST_WORK;
                end
            end
            itc_pkg::ST_WORK: begin
                if (r_cmd == itc_pkg::CMD_FLUSH) begin
                    if (cnt_zero) begin
                        n_ovf   = 1'b0;
                        n_state = itc_pkg::ST_IDLE;
                    end else if (can_emit) begin
                        shift     = itc_pkg::SH_POP;
                        n_count   = r_count - CW'(1);
                        emit      = 1'b1;
                        emit_last = cnt_one;
                    end
                end else begin
                    case (kind) inside
                        itc_pkg::K_ALNUM: begin
                            if (can_emit) begin
                                emit      = 1'b1;
                                emit_char = r_char;
                                emit_last = 1'b1;
                                n_state   = itc_pkg::ST_IDLE;
                            end
                        end
                        itc_pkg::K_OPEN, itc_pkg::K_OPER: begin
                            if (kind == itc_pkg::K_OPER && !cnt_zero &&
                                top != itc_pkg::CODE_OPEN &&
                                !(itc_pkg::prec_hi(push_code) && !itc_pkg::prec_hi(top))) begin
                                // pop an operator of equal or higher precedence
                                if (can_emit) begin
                                    shift     = itc_pkg::SH_POP;
                                    n_count   = r_count - CW'(1);
                                    emit      = 1'b1;
                                    emit_last = cnt_one || next == itc_pkg::CODE_OPEN ||
                                                (itc_pkg::prec_hi(push_code) &&
                                                 !itc_pkg::prec_hi(next));
                                end
                            end else begin
                                if (full) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    shift   = itc_pkg::SH_PUSH;
                                    n_count = r_count + CW'(1);
                                end
                                n_state = itc_pkg::ST_IDLE;
                            end
                        end
                        itc_pkg::K_CLOSE: begin
                            if (cnt_zero) begin
                                n_state = itc_pkg::ST_IDLE;
                            end else if (top == itc_pkg::CODE_OPEN) begin
                                // discard the matching '('
                                shift   = itc_pkg::SH_POP;
                                n_count = r_count - CW'(1);
                                n_state = itc_pkg::ST_IDLE;
                            end else if (can_emit) begin
                                shift     = itc_pkg::SH_POP;
                                n_count   = r_count - CW'(1);
                                emit      = 1'b1;
                                emit_last = cnt_one || next == itc_pkg::CODE_OPEN;
                            end
                        end
                        default: begin
                            n_state = itc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            default: n_state = itc_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itc_pkg::ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd  <= i_in.command;
            r_char <= i_in.char_in;
        end
        if (emit) begin
            r_out_char <= emit_char;
            r_out_last <= emit_last;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.char_out = r_out_char;
    assign o_out.run_last = r_out_last;
    assign o_out.overflow = r_out_ovf;

endmodule

// File: design/itc_cell.sv
// One stack entry; push takes the entry above, pop takes the entry below
module itc_cell (
    input  logic            i_clk,
    input  itc_pkg::t_shift i_shift,
    input  itc_pkg::t_code  i_from_up,
    input  itc_pkg::t_code  i_from_down,
    output itc_pkg::t_code  o_code
);

    itc_pkg::t_code r_code;
    itc_pkg::t_code n_code;

    always_comb begin
        case (i_shift)
            itc_pkg::SH_PUSH: n_code = i_from_up;
            itc_pkg::SH_POP:  n_code = i_from_down;
            default:          n_code = r_code;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_code = r_code;

endmodule
